/* hw/rtl/u2u_pkg.sv */
package u2u_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned CpW    = 21;
  localparam int unsigned NeedW  = 2;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [CpW-1:0]   CpMax     = 21'h10FFFF;
  localparam logic [CpW-1:0]   UnitMax   = 21'h00FFFF;
  localparam logic [CpW-1:0]   SurrFirst = 21'h00D800;
  localparam logic [CpW-1:0]   SurrLast  = 21'h00DFFF;
  localparam logic [CpW-1:0]   SuppBase  = 21'h010000;
  localparam logic [UnitW-1:0] SurrHigh  = 16'hD800;
  localparam logic [UnitW-1:0] SurrLow   = 16'hDC00;
  localparam logic [9:0]       Low10Mask = 10'h3FF;
  localparam logic [5:0]       ContMask  = 6'h3F;

  typedef enum logic [1:0] {
    KIND_UNIT,
    KIND_PAIR,
    KIND_ERROR
  } kind_e;

  // one classified entry between front and back
  typedef struct packed {
    kind_e            kind;
    logic [UnitW-1:0] unit0;
    logic [UnitW-1:0] unit1;
    logic             ends;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

/* hw/rtl/u2u_if.sv */
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_error;
  logic        last_of_run;
  logic        ends_string;

  modport source (output valid, output code_unit, output is_error, output last_of_run,
                  output ends_string, input ready);
  modport sink   (input valid, input code_unit, input is_error, input last_of_run,
                  input ends_string, output ready);
endinterface

/* hw/rtl/utf8_to_utf16_transcoder_unit.sv */
// UTF-8 to UTF-16 transcoder. One UTF-8 byte enters per item on src_i, with
// string_end marking the last byte of a string; dst_o gives UTF-16 code units,
// a surrogate pair for code points above 0xFFFF, or one error item for bad
// lead or continuation bytes, truncated sequences, surrogate code points and
// values above 0x10FFFF (overlong forms pass). After an error the rest of the
// string is dropped silently. A byte is taken every cycle while the decode
// queue has room; the output side sends one item per cycle while dst_o is
// ready, so a surrogate pair occupies the output register for two items.
// Since a pair needs four input bytes, the sustained rate is one byte per
// cycle while dst_o is ready. Results pass the queue and an output register.
module utf8_to_utf16_transcoder_unit #(
  parameter int unsigned QueueDepth = u2u_pkg::QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  u2u_in_if.sink    src_i,
  u2u_out_if.source dst_o
);
  import u2u_pkg::*;

  push_t push;
  head_t head;
  logic  full;
  logic  pop;
  logic  accept;

  assign src_i.ready = !full;
  assign accept      = src_i.valid && !full;

  u2u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .in_byte_i    (src_i.in_byte),
    .string_end_i (src_i.string_end),
    .accept_i     (accept),
    .push_o       (push)
  );

  u2u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  u2u_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (dst_o.valid),
    .out_ready_i   (dst_o.ready),
    .code_unit_o   (dst_o.code_unit),
    .is_error_o    (dst_o.is_error),
    .last_of_run_o (dst_o.last_of_run),
    .ends_string_o (dst_o.ends_string)
  );

endmodule

/* hw/rtl/u2u_front.sv */
module u2u_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   string_end_i,
  input  logic                   accept_i,
  output u2u_pkg::push_t         push_o
);
  import u2u_pkg::*;

  logic [CpW-1:0]   cp_q, cp_d;
  logic [NeedW-1:0] need_q, need_d;
  logic             skip_q, skip_d;

  logic [CpW-1:0]   cp_shift;
  logic [CpW-1:0]   cp_off;
  logic             cp_bad;
  logic             is_cont;

  assign cp_shift = {cp_q[CpW-7:0], in_byte_i[5:0] & ContMask};
  assign cp_off   = cp_shift - SuppBase;
  assign cp_bad   = (cp_shift >= SurrFirst && cp_shift <= SurrLast) || cp_shift > CpMax;
  assign is_cont  = in_byte_i inside {[8'h80:8'hBF]};

  always_comb begin
    entry_t e;
    logic   err;
    cp_d   = cp_q;
    need_d = need_q;
    skip_d = skip_q;
    err    = 1'b0;
    e.kind  = KIND_UNIT;
    e.unit0 = '0;
    e.unit1 = '0;
    e.ends  = string_end_i;
    push_o.valid = 1'b0;

    if (accept_i) begin
      if (skip_q) begin
        if (string_end_i) skip_d = 1'b0;
      end else if (need_q == '0) begin
        if (in_byte_i <= 8'h7F) begin
          push_o.valid = 1'b1;
          e.unit0 = {8'h00, in_byte_i};
        end else if (is_cont || in_byte_i >= 8'hF8) begin
          err = 1'b1;
        end else if (string_end_i) begin
          err = 1'b1;
        end else if (in_byte_i <= 8'hDF) begin
          cp_d   = {16'h0, in_byte_i[4:0]};
          need_d = 2'd1;
        end else if (in_byte_i <= 8'hEF) begin
          cp_d   = {17'h0, in_byte_i[3:0]};
          need_d = 2'd2;
        end else begin
          cp_d   = {18'h0, in_byte_i[2:0]};
          need_d = 2'd3;
        end
      end else if (!is_cont) begin
        err = 1'b1;
      end else if (need_q == 2'd1) begin
        cp_d   = '0;
        need_d = '0;
        if (cp_bad) begin
          err = 1'b1;
        end else if (cp_shift <= UnitMax) begin
          push_o.valid = 1'b1;
          e.unit0 = cp_shift[UnitW-1:0];
        end else begin
          push_o.valid = 1'b1;
          e.kind  = KIND_PAIR;
          e.unit0 = SurrHigh + {6'h0, cp_off[19:10]};
          e.unit1 = SurrLow + {6'h0, cp_off[9:0] & Low10Mask};
        end
      end else if (string_end_i) begin
        err = 1'b1;
      end else begin
        cp_d   = cp_shift;
        need_d = need_q - 2'd1;
      end

      if (err) begin
        push_o.valid = 1'b1;
        e.kind  = KIND_ERROR;
        e.unit0 = '0;
        cp_d    = '0;
        need_d  = '0;
        skip_d  = !string_end_i;
      end
    end
    push_o.entry = e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q   <= '0;
      need_q <= '0;
      skip_q <= 1'b0;
    end else if (in_valid_i) begin
      cp_q   <= cp_d;
      need_q <= need_d;
      skip_q <= skip_d;
    end
  end

endmodule

/* hw/rtl/u2u_queue.sv */
module u2u_queue #(
  parameter int unsigned Depth = u2u_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  u2u_pkg::push_t push_i,
  input  logic           pop_i,
  output u2u_pkg::head_t head_o,
  output logic           full_o
);
  import u2u_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign do_pop       = pop_i && cnt_q != '0;
  assign full_o       = cnt_q == Full;
  assign head_o.valid = cnt_q != '0;
  assign head_o.entry = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.valid) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i.valid && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i.valid && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.entry;
  end

endmodule

/* hw/rtl/u2u_back.sv */
module u2u_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  u2u_pkg::head_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [15:0]    code_unit_o,
  output logic           is_error_o,
  output logic           last_of_run_o,
  output logic           ends_string_o
);
  import u2u_pkg::*;

  logic             valid_q, valid_d;
  logic             second_q, second_d;   // low surrogate still to send
  logic [UnitW-1:0] low_q, low_d;
  logic             low_end_q, low_end_d;
  logic [UnitW-1:0] unit_q, unit_d;
  logic             err_q, err_d, last_q, last_d, end_q, end_d;
  logic             load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d   = valid_q;
    second_d  = second_q;
    low_d     = low_q;
    low_end_d = low_end_q;
    unit_d    = unit_q;
    err_d     = err_q;
    last_d    = last_q;
    end_d     = end_q;
    pop_o     = 1'b0;
    if (load) begin
      if (second_q) begin
        valid_d  = 1'b1;
        unit_d   = low_q;
        err_d    = 1'b0;
        last_d   = 1'b1;
        end_d    = low_end_q;
        second_d = 1'b0;
      end else if (head_i.valid) begin
        pop_o     = 1'b1;
        valid_d   = 1'b1;
        unit_d    = head_i.entry.unit0;
        err_d     = head_i.entry.kind == KIND_ERROR;
        last_d    = head_i.entry.kind != KIND_PAIR;
        end_d     = head_i.entry.ends;
        second_d  = head_i.entry.kind == KIND_PAIR;
        low_d     = head_i.entry.unit1;
        low_end_d = head_i.entry.ends;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q     <= low_d;
    low_end_q <= low_end_d;
    unit_q    <= unit_d;
    err_q     <= err_d;
    last_q    <= last_d;
    end_q     <= end_d;
  end

  assign out_valid_o   = valid_q;
  assign code_unit_o   = unit_q;
  assign is_error_o    = err_q;
  assign last_of_run_o = last_q;
  assign ends_string_o = end_q;

endmodule

/* test/tb_utf8_to_utf16_transcoder_unit.sv */
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder_unit;
  import u2u_pkg::*;

  localparam int unsigned QuietLimit = 500;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ByteTarget = 1550;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             err;
    logic             last;
    logic             ends;
  } utf16_result_t;

  // pinned rows carry their expected single result in the table
  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             ends;
    logic             pinned;
    logic [UnitW-1:0] unit;
    logic             err;
  } probe_row_t;

  localparam probe_row_t ProbeRows [25] = '{
    '{8'h00, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 16'h007F, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h82, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hAC, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b1, 16'h0000, 1'b1},   // bad lead, rest of string dropped
    '{8'h41, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{8'hC2, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h41, 1'b1, 1'b1, 16'h0000, 1'b1},   // bad continuation
    '{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h82, 1'b1, 1'b1, 16'h0000, 1'b1},   // string ends mid-sequence
    '{8'hED, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 1'b1, 16'h0000, 1'b1},   // surrogate code point
    '{8'hF4, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h90, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 1'b1, 16'h0000, 1'b1},   // above 0x10FFFF
    '{8'hC0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 1'b1, 16'h0000, 1'b0}    // overlong NUL passes
  };

  logic clk_i;
  logic rst_ni;

  u2u_in_if  src_if ();
  u2u_out_if dst_if ();

  utf8_to_utf16_transcoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_if),
    .dst_o  (dst_if)
  );

  // decoder shadow state
  logic [CpW-1:0]   cp_acc;
  logic [NeedW-1:0] cont_left;
  logic             skip_rest;

  utf16_result_t step_units[$];
  utf16_result_t pending_units[$];

  int unsigned bytes_sent;
  int unsigned units_checked;
  int unsigned error_units;
  int unsigned pair_units;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned src_calm;
  int unsigned dst_calm;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned pick_wait(inout int unsigned calm);
    int unsigned gap;
    if (calm != 0) begin
      calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 29) == 0) calm = $urandom_range(20, 60);
    end
    return gap;
  endfunction

  function automatic utf16_result_t make_unit(input logic [UnitW-1:0] unit, input logic err,
                                              input logic last, input logic ends);
    utf16_result_t r;
    r.unit = unit;
    r.err  = err;
    r.last = last;
    r.ends = ends;
    return r;
  endfunction

  function automatic void flag_bad_utf8(input logic ends);
    step_units.insert(step_units.size(), make_unit('0, 1'b1, 1'b1, ends));
    cp_acc = '0;
    cont_left = '0;
    skip_rest = !ends;
  endfunction

  // one byte in, zero to two UTF-16 results into step_units
  function automatic void decode_utf8_byte(input logic [ByteW-1:0] b, input logic ends);
    logic [CpW-1:0] cp;
    step_units.delete();
    if (skip_rest) begin
      if (ends) skip_rest = 1'b0;
      return;
    end
    if (cont_left == 0) begin
      if (b <= 8'h7F) begin
        step_units.insert(step_units.size(), make_unit({8'h00, b}, 1'b0, 1'b1, ends));
      end else if (b <= 8'hBF || b >= 8'hF8 || ends) begin
        flag_bad_utf8(ends);
      end else if (b <= 8'hDF) begin
        cp_acc = CpW'(b[4:0]);
        cont_left = 2'd1;
      end else if (b <= 8'hEF) begin
        cp_acc = CpW'(b[3:0]);
        cont_left = 2'd2;
      end else begin
        cp_acc = CpW'(b[2:0]);
        cont_left = 2'd3;
      end
      return;
    end
    if (b[7:6] != 2'b10) begin
      flag_bad_utf8(ends);
      return;
    end
    cp_acc = {cp_acc[CpW-7:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left != 0) begin
      if (ends) flag_bad_utf8(ends);
      return;
    end
    cp = cp_acc;
    cp_acc = '0;
    if ((cp >= SurrFirst && cp <= SurrLast) || cp > CpMax) begin
      flag_bad_utf8(ends);
    end else if (cp <= UnitMax) begin
      step_units.insert(step_units.size(), make_unit(cp[UnitW-1:0], 1'b0, 1'b1, ends));
    end else begin
      cp = cp - SuppBase;
      step_units.insert(step_units.size(),
                        make_unit(SurrHigh + UnitW'(cp[19:10]), 1'b0, 1'b0, ends));
      step_units.insert(step_units.size(),
                        make_unit(SurrLow + UnitW'(cp[9:0]), 1'b0, 1'b1, ends));
    end
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic ends,
                           input logic pinned, input logic [UnitW-1:0] unit,
                           input logic err);
    int unsigned gap;
    gap = pick_wait(src_calm);
    if (gap != 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_if.valid      <= 1'b1;
    src_if.in_byte    <= b;
    src_if.string_end <= ends;
    @(negedge clk_i);
    while (!src_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    bytes_sent++;
    decode_utf8_byte(b, ends);
    if (pinned) begin
      pending_units.insert(pending_units.size(), make_unit(unit, err, 1'b1, ends));
    end else begin
      foreach (step_units[i]) pending_units.insert(pending_units.size(), step_units[i]);
    end
  endtask

  // mostly well-formed strings with random content, some of them damaged
  task automatic send_random_string();
    logic [ByteW-1:0] bytes[$];
    logic [CpW-1:0]   cp;
    int unsigned      nchar;
    int unsigned      nb;
    int unsigned      pos;
    int unsigned      flaw;
    nchar = $urandom_range(1, 6);
    repeat (nchar) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          nb = 1;
          cp = CpW'($urandom_range(0, 16'h007F));
        end
        4, 5: begin
          nb = 2;
          cp = CpW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'h07FF)
                                                : $urandom_range(16'h0080, 16'h07FF));
        end
        6, 7: begin
          nb = 3;
          cp = CpW'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 16'h07FF)
                                                 : $urandom_range(16'h0800, 16'hFFFF));
        end
        default: begin
          nb = 4;
          cp = CpW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 21'h1FFFFF)
                                                : $urandom_range(21'h010000, 21'h10FFFF));
        end
      endcase
      case (nb)
        1: bytes.insert(bytes.size(), {1'b0, cp[6:0]});
        2: begin
          bytes.insert(bytes.size(), {3'b110, cp[10:6]});
          bytes.insert(bytes.size(), {2'b10, cp[5:0]});
        end
        3: begin
          bytes.insert(bytes.size(), {4'b1110, cp[15:12]});
          bytes.insert(bytes.size(), {2'b10, cp[11:6]});
          bytes.insert(bytes.size(), {2'b10, cp[5:0]});
        end
        default: begin
          bytes.insert(bytes.size(), {5'b11110, cp[20:18]});
          bytes.insert(bytes.size(), {2'b10, cp[17:12]});
          bytes.insert(bytes.size(), {2'b10, cp[11:6]});
          bytes.insert(bytes.size(), {2'b10, cp[5:0]});
        end
      endcase
    end
    flaw = $urandom_range(0, 19);
    pos = $urandom_range(0, bytes.size() - 1);
    case (flaw)
      0: bytes[pos] = ByteW'($urandom_range(0, 255));
      1: if (bytes.size() > 1) void'(bytes.pop_back());
      2: bytes.insert(pos, ByteW'($urandom_range(0, 255)));
      default: ;
    endcase
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, 1'b0, '0, 1'b0);
  endtask

  initial begin
    src_if.valid      = 1'b0;
    src_if.in_byte    = '0;
    src_if.string_end = 1'b0;
    dst_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    cp_acc            = '0;
    cont_left         = '0;
    skip_rest         = 1'b0;
    bytes_sent        = 0;
    units_checked     = 0;
    error_units       = 0;
    pair_units        = 0;
    fail_count        = 0;
    src_calm          = 0;
    dst_calm          = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (ProbeRows[i]) begin
      send_byte(ProbeRows[i].b, ProbeRows[i].ends, ProbeRows[i].pinned,
                ProbeRows[i].unit, ProbeRows[i].err);
    end
    src_if.valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk_i);

    while (bytes_sent < ByteTarget) begin
      if (bytes_sent >= ByteTarget / 2 && bytes_sent < ByteTarget / 2 + 8) begin
        src_if.valid <= 1'b0;
        while (pending_units.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 2) == 0, 1'b0, '0, 1'b0);
      end else begin
        send_random_string();
      end
    end
    src_if.valid <= 1'b0;

    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("bytes sent %0d, UTF-16 results checked %0d (%0d surrogate pairs, %0d errors)",
             bytes_sent, units_checked, pair_units, error_units);
    $display("mismatches %0d", fail_count);
    if (fail_count == 0) begin
      $display("tb_utf8_to_utf16_transcoder_unit: done, clean");
    end else begin
      $display("tb_utf8_to_utf16_transcoder_unit: done, errors");
    end
    $finish;
  end

  // receiver ready pattern
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = pick_wait(dst_calm);
      if (gap != 0) begin
        dst_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      dst_if.ready <= 1'b1;
      @(negedge clk_i);
      while (!dst_if.valid) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  // outputs are stable at the falling edge before the accepting rising edge
  always @(negedge clk_i) begin : check_results
    utf16_result_t want;
    if (rst_ni && dst_if.valid && dst_if.ready) begin
      if (pending_units.size() == 0) begin
        $error("unexpected result: code_unit %h is_error %b last_of_run %b ends_string %b",
               dst_if.code_unit, dst_if.is_error, dst_if.last_of_run, dst_if.ends_string);
        fail_count++;
      end else begin
        want = pending_units.pop_front();
        units_checked++;
        if (want.err) error_units++;
        if (!want.err && !want.last) pair_units++;
        if (dst_if.code_unit !== want.unit) begin
          $error("code_unit: expected %h, got %h", want.unit, dst_if.code_unit);
          fail_count++;
        end
        if (dst_if.is_error !== want.err) begin
          $error("is_error: expected %b, got %b", want.err, dst_if.is_error);
          fail_count++;
        end
        if (dst_if.last_of_run !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, dst_if.last_of_run);
          fail_count++;
        end
        if (dst_if.ends_string !== want.ends) begin
          $error("ends_string: expected %b, got %b", want.ends, dst_if.ends_string);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("no item moved for %0d cycles", QuietLimit);
      $display("tb_utf8_to_utf16_transcoder_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
